// File: src/calendar_day_difference_assert.svh
// assertion macros for the calendar day difference port checker
// expects clk and rst_n in the scope where a macro is used
`ifndef CALENDAR_DAY_DIFFERENCE_ASSERT_SVH
`define CALENDAR_DAY_DIFFERENCE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cdd_pkg.sv
// package for the calendar day difference block
// widths, the year info struct and the month length table; no dependencies
package cdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int ACC_W   = 23;  // ordinal day number of any 14-bit year fits

  // year / 100 by reciprocal: floor(y * 5243 / 2^19) is exact for y < 16384
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int Q100_W      = PROD_W - RECIP_SHIFT;
  localparam int R100_W      = 7;
  localparam int C4_W        = YEAR_W - 1;
  localparam int C400_W      = 6;

  localparam logic [MONTH_W-1:0] MONTHS    = MONTH_W'(12);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic              leap;
    logic [C4_W-1:0]   c4;    // ceil(y / 4)
    logic [Q100_W-1:0] c100;  // ceil(y / 100)
    logic [C400_W-1:0] c400;  // ceil(y / 400)
    logic [ACC_W-1:0]  y365;  // 365 * y
  } year_info_t;

  // days in month m, zero for a month outside 1..12
  function automatic logic [DAY_W-1:0] month_len_f(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                        len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                     len = '0;
    endcase
    return len;
  endfunction

endpackage

// File: src/cdd_year_unit.sv
// two-stage year unit: leap flag and the year terms of the day number
// depends on cdd_pkg
module cdd_year_unit import cdd_pkg::*; (
  input  logic              clk,
  input  logic [YEAR_W-1:0] year,
  output year_info_t        info
);

  logic [PROD_W-1:0] prod_r;
  logic [YEAR_W-1:0] year_r;
  year_info_t        info_r;
  year_info_t        info_nxt;

  logic [Q100_W-1:0] q100;
  logic [YEAR_W-1:0] r100_full;
  logic [R100_W-1:0] r100;
  logic              r_zero;
  logic              div400;

  always_comb begin
    q100      = prod_r[PROD_W-1:RECIP_SHIFT];
    r100_full = year_r - YEAR_W'(q100) * YEAR_W'(100);
    r100      = r100_full[R100_W-1:0];
    r_zero    = (r100 == '0);
    div400    = r_zero && (q100[1:0] == 2'b00);

    info_nxt.leap = div400 || ((year_r[1:0] == 2'b00) && !r_zero);
    info_nxt.c4   = C4_W'(year_r >> 2) + C4_W'(year_r[1:0] != 2'b00);
    info_nxt.c100 = q100 + Q100_W'(!r_zero);
    info_nxt.c400 = C400_W'(q100 >> 2) + C400_W'(!div400);
    info_nxt.y365 = ACC_W'(year_r) * ACC_W'(365);
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(year) * PROD_W'(RECIP_100);
    year_r <= year;
    info_r <= info_nxt;
  end

  assign info = info_r;

endmodule

// File: src/calendar_day_difference.sv
// top level of the calendar day difference block
// depends on cdd_pkg and cdd_year_unit

// Counts the days from a start date to an end date in the Gregorian
// calendar (leap years by the 400/4/100 rule). A word is taken when start
// is high and busy is low; busy then stays high until the result is out.
// The result is shown on out_day_count and out_invalid_date for exactly one
// cycle, marked by out_valid, and the receiver cannot stall it, so it must
// capture the word in that cycle. A date with a month outside 1..12 or a
// day of 0 or past its month's end sets out_invalid_date with a count of 0.
// A start date that is not before the end date counts 0, plus one when
// in_include_end_day is set; counts above the 22-bit range saturate.
// One shared accumulator sums, per date, 365*y, one month length per cycle
// for the months before the given one, the three leap day corrections and
// the day; a two-stage year unit with a reciprocal multiply feeds it. The
// block keeps nothing between words.
module calendar_day_difference import cdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  in_start_year,
  input  logic [MONTH_W-1:0] in_start_month,
  input  logic [DAY_W-1:0]   in_start_day,
  input  logic [YEAR_W-1:0]  in_end_year,
  input  logic [MONTH_W-1:0] in_end_month,
  input  logic [DAY_W-1:0]   in_end_day,
  input  logic               in_include_end_day,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_day_count,
  output logic               out_invalid_date
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_YEAR0,   // year unit stage one
    S_YEAR1,   // year unit stage two
    S_BASE,    // load 365*y, check the date
    S_MONTH,   // add whole months, one per cycle
    S_C4,
    S_C100,
    S_C400,
    S_DAY,
    S_NEXT,    // switch to the end date or finish
    S_DIFF,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // latched input word
  logic [YEAR_W-1:0]  sy_r, sy_nxt, ey_r, ey_nxt;
  logic [MONTH_W-1:0] sm_r, sm_nxt, em_r, em_nxt;
  logic [DAY_W-1:0]   sd_r, sd_nxt, ed_r, ed_nxt;
  logic               inc_r, inc_nxt;

  // sequencer state
  logic               sel_r, sel_nxt;    // 0 start date, 1 end date
  logic [MONTH_W-1:0] k_r, k_nxt;        // month loop counter
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W-1:0]   ord_a_r, ord_a_nxt;
  logic               inv_r, inv_nxt;

  // registered result
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_inv_r, out_inv_nxt;

  // datapath
  logic [YEAR_W-1:0]  year_in;
  year_info_t         info;
  logic [MONTH_W-1:0] cur_m;
  logic [DAY_W-1:0]   cur_d;
  logic [DAY_W-1:0]   cur_len;
  logic               bad_date;
  logic [ACC_W-1:0]   opnd;
  logic               sub;
  logic [ACC_W-1:0]   acc_sum;
  logic [ACC_W:0]     total;

  assign busy    = (state_r != S_IDLE);
  assign year_in = sel_r ? ey_r : sy_r;
  assign cur_m   = sel_r ? em_r : sm_r;
  assign cur_d   = sel_r ? ed_r : sd_r;

  cdd_year_unit u_year (
    .clk  (clk),
    .year (year_in),
    .info (info)
  );

  assign cur_len  = month_len_f(cur_m, info.leap);
  assign bad_date = (cur_len == '0) || (cur_d == '0) || (cur_d > cur_len);

  // operand select for the shared accumulator
  always_comb begin
    opnd = '0;
    sub  = 1'b0;
    case (state_r)
      S_MONTH: opnd = ACC_W'(month_len_f(k_r, info.leap));
      S_C4:    opnd = ACC_W'(info.c4);
      S_C100: begin
        opnd = ACC_W'(info.c100);
        sub  = 1'b1;
      end
      S_C400:  opnd = ACC_W'(info.c400);
      S_DAY:   opnd = ACC_W'(cur_d) - ACC_W'(1);
      S_DIFF: begin
        opnd = ord_a_r;
        sub  = 1'b1;
      end
      default: opnd = '0;
    endcase
  end

  assign acc_sum = sub ? (acc_r - opnd) : (acc_r + opnd);
  assign total   = {1'b0, acc_r} + (ACC_W+1)'(inc_r);

  always_comb begin
    state_nxt     = state_r;
    sy_nxt        = sy_r;
    sm_nxt        = sm_r;
    sd_nxt        = sd_r;
    ey_nxt        = ey_r;
    em_nxt        = em_r;
    ed_nxt        = ed_r;
    inc_nxt       = inc_r;
    sel_nxt       = sel_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    ord_a_nxt     = ord_a_r;
    inv_nxt       = inv_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_inv_nxt   = out_inv_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          sy_nxt    = in_start_year;
          sm_nxt    = in_start_month;
          sd_nxt    = in_start_day;
          ey_nxt    = in_end_year;
          em_nxt    = in_end_month;
          ed_nxt    = in_end_day;
          inc_nxt   = in_include_end_day;
          sel_nxt   = 1'b0;
          inv_nxt   = 1'b0;
          state_nxt = S_YEAR0;
        end
      end
      S_YEAR0: state_nxt = S_YEAR1;
      S_YEAR1: state_nxt = S_BASE;
      S_BASE: begin
        acc_nxt   = info.y365;
        k_nxt     = MONTH_W'(1);
        inv_nxt   = inv_r | bad_date;
        state_nxt = S_MONTH;
      end
      S_MONTH: begin
        // bounded by twelve even for a bad month
        if ((k_r < cur_m) && (k_r <= MONTHS)) begin
          acc_nxt = acc_sum;
          k_nxt   = k_r + MONTH_W'(1);
        end else begin
          state_nxt = S_C4;
        end
      end
      S_C4: begin
        acc_nxt   = acc_sum;
        state_nxt = S_C100;
      end
      S_C100: begin
        acc_nxt   = acc_sum;
        state_nxt = S_C400;
      end
      S_C400: begin
        acc_nxt   = acc_sum;
        state_nxt = S_DAY;
      end
      S_DAY: begin
        acc_nxt   = acc_sum;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (!sel_r) begin
          ord_a_nxt = acc_r;
          sel_nxt   = 1'b1;
          state_nxt = S_YEAR0;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        // end not after start counts zero
        acc_nxt   = (acc_r > ord_a_r) ? acc_sum : '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_inv_nxt   = inv_r;
        if (inv_r) begin
          out_count_nxt = '0;
        end else if (total > (ACC_W+1)'(COUNT_MAX)) begin
          out_count_nxt = COUNT_MAX;
        end else begin
          out_count_nxt = total[COUNT_W-1:0];
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sy_r        <= sy_nxt;
    sm_r        <= sm_nxt;
    sd_r        <= sd_nxt;
    ey_r        <= ey_nxt;
    em_r        <= em_nxt;
    ed_r        <= ed_nxt;
    inc_r       <= inc_nxt;
    sel_r       <= sel_nxt;
    k_r         <= k_nxt;
    acc_r       <= acc_nxt;
    ord_a_r     <= ord_a_nxt;
    inv_r       <= inv_nxt;
    out_count_r <= out_count_nxt;
    out_inv_r   <= out_inv_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_day_count    = out_count_r;
  assign out_invalid_date = out_inv_r;

endmodule

// File: src/cdd_checker.sv
// port-level checker for the calendar day difference block, bound to the top
// depends on cdd_pkg and calendar_day_difference_assert.svh
`include "calendar_day_difference_assert.svh"

module cdd_checker import cdd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [COUNT_W-1:0] out_day_count,
  input logic               out_invalid_date
);

  // an accepted word keeps the block busy
  `CDD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

  // the result goes out once the block is free again
  `CDD_ASSERT_NOW(a_out_idle, out_valid, !busy, "result shown while still busy")

  // strobe lasts one cycle per word
  `CDD_ASSERT_NEXT(a_out_pulse, out_valid, !out_valid, "result strobe longer than a cycle")

  // bad date always reports a zero count
  `CDD_ASSERT_NOW(a_invalid_zero, out_valid && out_invalid_date, out_day_count == '0,
    "invalid date with a nonzero count")

endmodule

bind calendar_day_difference cdd_checker u_cdd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_day_count    (out_day_count),
  .out_invalid_date (out_invalid_date)
);

// File: tb/cdd_day_count_checker.sv
`timescale 1ns / 100ps
// day count checker for the calendar day difference block
// watches the command and result ports, predicts each result and compares; uses cdd_pkg
module cdd_day_count_checker import cdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [YEAR_W-1:0]  in_start_year,
  input  logic [MONTH_W-1:0] in_start_month,
  input  logic [DAY_W-1:0]   in_start_day,
  input  logic [YEAR_W-1:0]  in_end_year,
  input  logic [MONTH_W-1:0] in_end_month,
  input  logic [DAY_W-1:0]   in_end_day,
  input  logic               in_include_end_day,
  input  logic               out_valid,
  input  logic [COUNT_W-1:0] out_day_count,
  input  logic               out_invalid_date,
  output int unsigned        mismatch_count,
  output int unsigned        pending_count
);

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               invalid_date;
  } day_result_t;

  day_result_t expected_days[$];
  int unsigned mismatches = 0;

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit date_exists(int unsigned y, int unsigned m, int unsigned d);
    return (d >= 1) && (d <= month_length(m, y));
  endfunction

  // days since 0000-01-01, year zero counted as a leap year
  function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
    int unsigned n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < m; k++)
      n += month_length(k, y);
    return n + d - 1;
  endfunction

  function automatic day_result_t predict_days(
    logic [YEAR_W-1:0] sy, logic [MONTH_W-1:0] sm, logic [DAY_W-1:0] sd,
    logic [YEAR_W-1:0] ey, logic [MONTH_W-1:0] em, logic [DAY_W-1:0] ed, logic inc);
    day_result_t r;
    int unsigned from_day, to_day, span;
    r = '0;
    if (!date_exists(sy, sm, sd) || !date_exists(ey, em, ed)) begin
      r.invalid_date = 1'b1;
      return r;
    end
    from_day = day_number(sy, sm, sd);
    to_day   = day_number(ey, em, ed);
    span     = (to_day > from_day) ? to_day - from_day : 0;
    span    += inc;
    if (span > COUNT_MAX)
      span = COUNT_MAX;
    r.day_count = span[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    day_result_t want;
    if (rst_n) begin
      if (start && !busy)
        expected_days.push_back(predict_days(in_start_year, in_start_month, in_start_day,
                                             in_end_year, in_end_month, in_end_day,
                                             in_include_end_day));
      if (out_valid) begin
        if (expected_days.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result word count=%0d invalid=%0b", $realtime,
                     out_day_count, out_invalid_date);
          mismatches++;
        end else begin
          want = expected_days.pop_front();
          if (out_day_count !== want.day_count || out_invalid_date !== want.invalid_date) begin
            if (mismatches < 10)
              $display("%0t: result word wrong: count exp %0d got %0d, invalid exp %0b got %0b",
                       $realtime, want.day_count, out_day_count, want.invalid_date,
                       out_invalid_date);
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= expected_days.size();
  end

endmodule

// File: tb/tb_calendar_day_difference.sv
`timescale 1ns / 100ps
// testbench top for calendar_day_difference: directed and random date pairs
// depends on cdd_pkg, the block and cdd_day_count_checker
module tb_calendar_day_difference;
  import cdd_pkg::*;

  localparam int RANDOM_WORDS = 1180;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [YEAR_W-1:0]  in_start_year = '0;
  logic [MONTH_W-1:0] in_start_month = '0;
  logic [DAY_W-1:0]   in_start_day = '0;
  logic [YEAR_W-1:0]  in_end_year = '0;
  logic [MONTH_W-1:0] in_end_month = '0;
  logic [DAY_W-1:0]   in_end_day = '0;
  logic               in_include_end_day = 1'b0;
  logic               out_valid;
  logic [COUNT_W-1:0] out_day_count;
  logic               out_invalid_date;
  int unsigned        mismatch_count;
  int unsigned        pending_count;
  int unsigned        stall_cycles = 0;
  bit                 steady_feed = 1'b0;  // no idle gaps while set

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  calendar_day_difference u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_start_year      (in_start_year),
    .in_start_month     (in_start_month),
    .in_start_day       (in_start_day),
    .in_end_year        (in_end_year),
    .in_end_month       (in_end_month),
    .in_end_day         (in_end_day),
    .in_include_end_day (in_include_end_day),
    .out_valid          (out_valid),
    .out_day_count      (out_day_count),
    .out_invalid_date   (out_invalid_date)
  );

  cdd_day_count_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_start_year      (in_start_year),
    .in_start_month     (in_start_month),
    .in_start_day       (in_start_day),
    .in_end_year        (in_end_year),
    .in_end_month       (in_end_month),
    .in_end_day         (in_end_day),
    .in_include_end_day (in_include_end_day),
    .out_valid          (out_valid),
    .out_day_count      (out_day_count),
    .out_invalid_date   (out_invalid_date),
    .mismatch_count     (mismatch_count),
    .pending_count      (pending_count)
  );

  // watchdog: restarts on every accepted command or result word
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("calendar_day_difference: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // last day of a month, for building legal dates and dates one day past the end
  function automatic int unsigned last_day(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m);
    case (m)
      4'd2:                    return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default:                 return 31;
    endcase
  endfunction

  // mostly years in common use, some across the whole 14-bit field,
  // some on century and 400-year turns where the leap rule bites
  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(0, 7))
      0:       return YEAR_W'($urandom_range(0, 16383));
      1:       return YEAR_W'(400 * $urandom_range(0, 40) + 100 * $urandom_range(0, 3));
      default: return YEAR_W'($urandom_range(1, 9999));
    endcase
  endfunction

  // presents one command word after a random gap and holds it until taken
  task automatic send_dates(
    input logic [YEAR_W-1:0] sy, input logic [MONTH_W-1:0] sm, input logic [DAY_W-1:0] sd,
    input logic [YEAR_W-1:0] ey, input logic [MONTH_W-1:0] em, input logic [DAY_W-1:0] ed,
    input logic inc);
    int unsigned gap;
    gap = 0;
    if (!steady_feed) begin
      // now and then a long gap so the next word lands after busy falls
      if ($urandom_range(0, 7) == 0)
        gap = $urandom_range(0, 60);
      else
        while ($urandom_range(0, 99) < 28) gap++;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_start_year      <= sy;
    in_start_month     <= sm;
    in_start_day       <= sd;
    in_end_year        <= ey;
    in_end_month       <= em;
    in_end_day         <= ed;
    in_include_end_day <= inc;
    // taken at the first edge where busy was low
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  initial begin
    logic [YEAR_W-1:0]  sy, ey;
    logic [MONTH_W-1:0] sm, em;
    logic [DAY_W-1:0]   sd, ed;
    int unsigned        mode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of the fields
    send_dates(1, 1, 1, 1, 1, 1, 0);                // same date, nothing counted
    send_dates(1, 1, 1, 1, 1, 1, 1);                // same date, end day counted
    send_dates(1, 1, 1, 9999, 12, 31, 1);           // whole range in use
    send_dates(0, 1, 1, 1, 1, 1, 0);                // year zero is a leap year
    send_dates(0, 2, 29, 0, 3, 1, 0);               // feb 29 of year zero
    send_dates(16383, 12, 31, 0, 1, 1, 1);          // start after end, flag only
    send_dates(0, 1, 1, 16383, 12, 31, 0);          // count saturates
    send_dates(16383, 1, 1, 16383, 12, 31, 1);      // top year
    // leap rule
    send_dates(2000, 2, 29, 2000, 3, 1, 0);
    send_dates(1900, 2, 29, 1900, 3, 1, 0);         // century, not leap
    send_dates(2100, 2, 28, 2100, 3, 1, 1);
    send_dates(2400, 2, 29, 2401, 2, 28, 0);
    send_dates(2001, 1, 1, 2001, 2, 29, 1);         // end date impossible
    send_dates(1999, 12, 31, 2000, 1, 1, 0);
    send_dates(2023, 12, 31, 2024, 1, 1, 1);
    // start not before end
    send_dates(2024, 1, 31, 2023, 12, 31, 0);
    // impossible dates, most with the flag set to show it is ignored; last a legal same date
    send_dates(2023, 4, 31, 2023, 5, 1, 1);
    send_dates(2023, 1, 1, 2023, 13, 1, 1);
    send_dates(2023, 0, 10, 2023, 1, 1, 1);
    send_dates(2023, 15, 31, 2023, 1, 1, 0);
    send_dates(2023, 5, 0, 2023, 6, 1, 1);
    send_dates(2023, 5, 1, 2023, 6, 0, 0);
    send_dates(2023, 12, 31, 2023, 12, 31, 1);

    // random: mostly legal date pairs, some one step off, some raw bits
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady_feed = (i >= 400 && i < 600);
      mode = $urandom_range(0, 99);
      sy = pick_year();
      sm = MONTH_W'($urandom_range(1, 12));
      sd = ($urandom_range(0, 3) == 0) ? DAY_W'(last_day(sy, sm) - $urandom_range(0, 2))
                                       : DAY_W'($urandom_range(1, last_day(sy, sm)));
      // end year close to the start so small counts and both orders show up
      case ($urandom_range(0, 3))
        0:       ey = sy;
        1:       ey = (sy == '1) ? sy : sy + 1'b1;
        2:       ey = (sy == '0) ? sy : sy - 1'b1;
        default: ey = pick_year();
      endcase
      em = MONTH_W'($urandom_range(1, 12));
      ed = ($urandom_range(0, 3) == 0) ? DAY_W'(last_day(ey, em) - $urandom_range(0, 2))
                                       : DAY_W'($urandom_range(1, last_day(ey, em)));
      if (mode >= 70 && mode < 82) begin
        // one date just outside its month or with a bad month
        case ($urandom_range(0, 3))
          0:       sd = DAY_W'(last_day(sy, sm) + 1);
          1:       ed = DAY_W'(last_day(ey, em) + 1);
          2:       sd = '0;
          default: em = ($urandom_range(0, 1) == 1) ? MONTH_W'($urandom_range(13, 15)) : '0;
        endcase
      end else if (mode >= 82) begin
        sy = YEAR_W'($urandom);
        sm = MONTH_W'($urandom);
        sd = DAY_W'($urandom);
        ey = YEAR_W'($urandom);
        em = MONTH_W'($urandom);
        ed = DAY_W'($urandom);
      end
      send_dates(sy, sm, sd, ey, em, ed, 1'($urandom));
    end
    start <= 1'b0;

    // let the checker see the last word, then wait for every result
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0)
      $display("calendar_day_difference: match");
    else
      $display("calendar_day_difference: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/cdd_pkg.sv
src/cdd_year_unit.sv
src/calendar_day_difference.sv
src/cdd_checker.sv
tb/cdd_day_count_checker.sv
tb/tb_calendar_day_difference.sv
